>>> sv/uplh_pkg.sv
// Shared types and constants for the ultrasonic presence light hold unit.
`default_nettype none
package uplh_pkg;

   localparam int DIST_W      = 15;
   localparam int HIST_W      = 13;
   localparam int COUNT_W     = 16;
   localparam int SECONDS_W   = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int OPCODE_W    = 2;

   localparam int HISTORY_DEPTH_DEFAULT = 4;

   localparam logic [OPCODE_W-1:0] OP_ECHO0 = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ECHO1 = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GATE_ENABLE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GATE_LEVEL  = 2'd3;

   // count * 34 / 100 == (count * 34 * ceil(2^29 / 100)) >> 29 for all 16-bit counts
   localparam int                PROD_W     = 44;
   localparam int                DIST_SHIFT = 29;
   localparam logic [27:0]       DIST_SCALE = 28'd182536140;

   localparam logic [DIST_W-1:0] MIN_DIST_MM = 15'd20;
   localparam logic [DIST_W-1:0] MAX_DIST_MM = 15'd4500;

   localparam logic [HIST_W-1:0]    THRESHOLD_RESET = 13'd1000;
   localparam logic [SECONDS_W-1:0] HOLD_RESET      = 16'd30;

   typedef struct packed {
      logic [DIST_W-1:0] dist_mm;
      logic              in_range;
   } dist_result_type;

endpackage
`default_nettype wire

>>> sv/uplh_dist.sv
// Echo count to millimeter conversion and range check.
`default_nettype none
module uplh_dist (
   input  wire logic [uplh_pkg::COUNT_W-1:0] count,
   output uplh_pkg::dist_result_type         result
);

   logic [uplh_pkg::PROD_W-1:0]  prod;
   logic [uplh_pkg::DIST_W-1:0]  dist_mm;

   assign prod = uplh_pkg::PROD_W'(count) * uplh_pkg::PROD_W'(uplh_pkg::DIST_SCALE);
   assign dist_mm = prod[uplh_pkg::DIST_SHIFT +: uplh_pkg::DIST_W];

   assign result.dist_mm  = dist_mm;
   assign result.in_range = (dist_mm > uplh_pkg::MIN_DIST_MM) &&
                            (dist_mm < uplh_pkg::MAX_DIST_MM);

endmodule
`default_nettype wire

>>> sv/ultrasonic_presence_light_hold_unit.sv
// Top level of the ultrasonic presence light hold unit.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  opcode, echo_count, photo_level
//   rsp      out        rsp_valid / rsp_stall  light_on, distance_mm, sample_accepted,
//                                               hold_left, elapsed_seconds
//   csr      in         csr_write_enable       csr_index, csr_write_data
//
// One word per cycle while the result side does not stall; each word passes
// through the input register, then conversion, history update and presence
// check into the result register. The echo multiply by a constant sets the longest path.
// Synchronous reset clears history, counters, light and valid flags.
// A stalled result holds the result register; req_stall rises once the input
// register is also full.
`default_nettype none
module ultrasonic_presence_light_hold_unit #(
   parameter int HISTORY_DEPTH = uplh_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [uplh_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire logic [uplh_pkg::COUNT_W-1:0]      req_echo_count,
   input  wire logic                              req_photo_level,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_light_on,
   output logic [uplh_pkg::DIST_W-1:0]            rsp_distance_mm,
   output logic                                   rsp_sample_accepted,
   output logic [uplh_pkg::SECONDS_W-1:0]         rsp_hold_left,
   output logic [uplh_pkg::SECONDS_W-1:0]         rsp_elapsed_seconds,

   input  wire logic                              csr_write_enable,
   input  wire logic [uplh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [uplh_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int SUM_W = uplh_pkg::HIST_W + $clog2(HISTORY_DEPTH);

   // configuration
   logic [uplh_pkg::HIST_W-1:0]    threshold_ff;
   logic [uplh_pkg::SECONDS_W-1:0] hold_seconds_ff;
   logic                           gate_enable_ff;
   logic                           gate_level_ff;

   // input register
   logic                           s1_valid_ff;
   logic [uplh_pkg::OPCODE_W-1:0]  s1_opcode_ff;
   logic [uplh_pkg::COUNT_W-1:0]   s1_count_ff;
   logic                           s1_photo_ff;

   // block state
   logic [uplh_pkg::HIST_W-1:0]    hist_ff [2][HISTORY_DEPTH];
   logic [1:0]                     fresh_ff;
   logic [1:0]                     quarter_ff;
   logic [uplh_pkg::SECONDS_W-1:0] second_ff;
   logic [uplh_pkg::SECONDS_W-1:0] hold_ff;
   logic                           light_ff;

   // result register
   logic                           rsp_valid_ff;
   logic [uplh_pkg::DIST_W-1:0]    rsp_dist_ff;
   logic                           rsp_accepted_ff;

   logic                           advance;
   logic                           fire;
   logic                           is_echo;
   logic                           is_tick;
   uplh_pkg::dist_result_type      dist_res;
   logic                           push;
   logic [SUM_W-1:0]               sum [2];
   logic [1:0]                     presence;
   logic                           second_wrap;
   logic [uplh_pkg::SECONDS_W-1:0] hold_dec;
   logic [uplh_pkg::SECONDS_W-1:0] hold_in;
   logic                           light_in;
   logic [uplh_pkg::DIST_W-1:0]    rsp_dist_in;
   logic                           rsp_accepted_in;

   uplh_dist u_dist (
      .count  (s1_count_ff),
      .result (dist_res)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   assign is_echo = (s1_opcode_ff == uplh_pkg::OP_ECHO0) || (s1_opcode_ff == uplh_pkg::OP_ECHO1);
   assign is_tick = (s1_opcode_ff == uplh_pkg::OP_TICK);
   assign push    = is_echo && dist_res.in_range;

   always_comb begin
      for (int s = 0; s < 2; s++) begin
         sum[s] = '0;
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            sum[s] = sum[s] + SUM_W'(hist_ff[s][k]);
         end
         presence[s] = fresh_ff[s] &&
                       ((sum[s] >> $clog2(HISTORY_DEPTH)) < SUM_W'(threshold_ff));
      end
   end

   assign second_wrap = (quarter_ff == 2'd3);
   assign hold_dec    = (second_wrap && (hold_ff != '0)) ? hold_ff - 1'b1 : hold_ff;
   assign hold_in     = (presence != 2'b00) ? hold_seconds_ff : hold_dec;
   assign light_in    = (hold_in != '0) && (!gate_enable_ff || (s1_photo_ff == gate_level_ff));

   assign rsp_dist_in     = is_echo ? dist_res.dist_mm : '0;
   assign rsp_accepted_in = push;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= uplh_pkg::THRESHOLD_RESET;
         hold_seconds_ff <= uplh_pkg::HOLD_RESET;
         gate_enable_ff  <= 1'b0;
         gate_level_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            uplh_pkg::CSR_THRESHOLD:   threshold_ff    <= csr_write_data[uplh_pkg::HIST_W-1:0];
            uplh_pkg::CSR_HOLD:        hold_seconds_ff <= csr_write_data;
            uplh_pkg::CSR_GATE_ENABLE: gate_enable_ff  <= csr_write_data[0];
            uplh_pkg::CSR_GATE_LEVEL:  gate_level_ff   <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_opcode_ff <= req_opcode;
         s1_count_ff  <= req_echo_count;
         s1_photo_ff  <= req_photo_level;
      end
   end

   // block state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
               hist_ff[s][k] <= '0;
            end
         end
         fresh_ff   <= 2'b00;
         quarter_ff <= 2'd0;
         second_ff  <= '0;
         hold_ff    <= '0;
         light_ff   <= 1'b0;
      end else if (fire) begin
         if (push) begin
            for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
               hist_ff[s1_opcode_ff[0]][k] <= hist_ff[s1_opcode_ff[0]][k-1];
            end
            hist_ff[s1_opcode_ff[0]][0] <= dist_res.dist_mm[uplh_pkg::HIST_W-1:0];
            fresh_ff[s1_opcode_ff[0]]   <= 1'b1;
         end
         if (is_tick) begin
            quarter_ff <= quarter_ff + 2'd1;
            if (second_wrap) begin
               second_ff <= second_ff + 1'b1;
            end
            fresh_ff <= 2'b00;
            hold_ff  <= hold_in;
            light_ff <= light_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_dist_ff     <= rsp_dist_in;
         rsp_accepted_ff <= rsp_accepted_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_light_on        = light_ff;
   assign rsp_distance_mm     = rsp_dist_ff;
   assign rsp_sample_accepted = rsp_accepted_ff;
   assign rsp_hold_left       = hold_ff;
   assign rsp_elapsed_seconds = second_ff;

`ifndef SYNTHESIS
   a_light_needs_hold: assert property (@(posedge clock) disable iff (reset)
      light_ff |-> (hold_ff != '0))
      else $error("light on with no hold time left");

   a_accepted_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sample_accepted) |->
         ((rsp_distance_mm > uplh_pkg::MIN_DIST_MM) && (rsp_distance_mm < uplh_pkg::MAX_DIST_MM)))
      else $error("stored sample outside distance window");

   a_second_step: assert property (@(posedge clock) disable iff (reset)
      (fire && is_tick && second_wrap) |=> (second_ff == $past(second_ff) + 1'b1))
      else $error("seconds count did not advance on fourth tick");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while a stage was free");
`endif

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the ultrasonic presence light hold unit.
`timescale 1ns / 100ps
module tb_top;

   localparam int DEPTH          = uplh_pkg::HISTORY_DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_WORDS    = 240;
   localparam int BURST_WORDS    = 12;
   localparam logic [uplh_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic                           light_on;
      logic [uplh_pkg::DIST_W-1:0]    distance_mm;
      logic                           sample_accepted;
      logic [uplh_pkg::SECONDS_W-1:0] hold_left;
      logic [uplh_pkg::SECONDS_W-1:0] elapsed_seconds;
   } light_word_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [uplh_pkg::OPCODE_W-1:0]    req_opcode;
   logic [uplh_pkg::COUNT_W-1:0]     req_echo_count;
   logic                             req_photo_level;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_light_on;
   logic [uplh_pkg::DIST_W-1:0]      rsp_distance_mm;
   logic                             rsp_sample_accepted;
   logic [uplh_pkg::SECONDS_W-1:0]   rsp_hold_left;
   logic [uplh_pkg::SECONDS_W-1:0]   rsp_elapsed_seconds;
   logic                             csr_write_enable;
   logic [uplh_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [uplh_pkg::CSR_DATA_W-1:0]  csr_write_data;

   // predicted block state and register copies
   logic [uplh_pkg::HIST_W-1:0]    echo_history [2][DEPTH];
   logic [1:0]                     fresh_mask;
   logic [1:0]                     quarter_ticks;
   logic [uplh_pkg::SECONDS_W-1:0] seconds_count;
   logic [uplh_pkg::SECONDS_W-1:0] hold_left_count;
   logic                           lamp_on;
   logic [uplh_pkg::HIST_W-1:0]    presence_threshold;
   logic [uplh_pkg::SECONDS_W-1:0] hold_reload;
   logic                           gate_enabled;
   logic                           gate_level;

   light_word_type expected_words[$];
   int             mismatch_count = 0;
   int             stall_left = 0;
   bit             idling = 1'b1;

   ultrasonic_presence_light_hold_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_echo_count      (req_echo_count),
      .req_photo_level     (req_photo_level),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_light_on        (rsp_light_on),
      .rsp_distance_mm     (rsp_distance_mm),
      .rsp_sample_accepted (rsp_sample_accepted),
      .rsp_hold_left       (rsp_hold_left),
      .rsp_elapsed_seconds (rsp_elapsed_seconds),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_prediction();
      int s;
      int k;
      for (s = 0; s < 2; s++) begin
         for (k = 0; k < DEPTH; k++) begin
            echo_history[s][k] = '0;
         end
      end
      fresh_mask         = '0;
      quarter_ticks      = '0;
      seconds_count      = '0;
      hold_left_count    = '0;
      lamp_on            = 1'b0;
      presence_threshold = uplh_pkg::THRESHOLD_RESET;
      hold_reload        = uplh_pkg::HOLD_RESET;
      gate_enabled       = 1'b0;
      gate_level         = 1'b0;
   endfunction

   function automatic void check_sensor(int s);
      int unsigned sum;
      int          k;
      if (fresh_mask[s]) begin
         fresh_mask[s] = 1'b0;
         sum = 0;
         for (k = 0; k < DEPTH; k++) begin
            sum += 32'(echo_history[s][k]);
         end
         if (sum / DEPTH < presence_threshold) begin
            hold_left_count = hold_reload;
         end
      end
   endfunction

   function automatic light_word_type predict_light(logic [uplh_pkg::OPCODE_W-1:0] op,
                                                    logic [uplh_pkg::COUNT_W-1:0] count,
                                                    logic photo);
      light_word_type w;
      int unsigned    dist_calc;
      int             k;
      w = '0;
      if (op == uplh_pkg::OP_ECHO0 || op == uplh_pkg::OP_ECHO1) begin
         dist_calc = (32'(count) * 34) / 100;
         if (dist_calc > uplh_pkg::MIN_DIST_MM && dist_calc < uplh_pkg::MAX_DIST_MM) begin
            for (k = DEPTH - 1; k > 0; k--) begin
               echo_history[op[0]][k] = echo_history[op[0]][k-1];
            end
            echo_history[op[0]][0] = dist_calc[uplh_pkg::HIST_W-1:0];
            fresh_mask[op[0]]      = 1'b1;
            w.sample_accepted      = 1'b1;
         end
         w.distance_mm = dist_calc[uplh_pkg::DIST_W-1:0];
      end else if (op == uplh_pkg::OP_TICK) begin
         quarter_ticks = quarter_ticks + 2'd1;
         if (quarter_ticks == 2'd0) begin
            seconds_count = seconds_count + 16'd1;
            if (hold_left_count != 0) begin
               hold_left_count = hold_left_count - 16'd1;
            end
         end
         check_sensor(0);
         check_sensor(1);
         lamp_on = (hold_left_count != 0) && (!gate_enabled || photo == gate_level);
      end
      w.light_on        = lamp_on;
      w.hold_left       = hold_left_count;
      w.elapsed_seconds = seconds_count;
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < 100) begin
         $display("ERROR %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      end
      mismatch_count++;
   endtask

   // check results first, then predict the word accepted at this edge
   always @(posedge clock) begin
      light_word_type got;
      light_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_light_on, rsp_distance_mm, rsp_sample_accepted,
                   rsp_hold_left, rsp_elapsed_seconds};
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", 32'(got.distance_mm), 32'd0);
            end else begin
               want = expected_words.pop_front();
               if (got.light_on !== want.light_on)
                  report_mismatch("light_on", 32'(got.light_on), 32'(want.light_on));
               if (got.distance_mm !== want.distance_mm)
                  report_mismatch("distance_mm", 32'(got.distance_mm),
                                  32'(want.distance_mm));
               if (got.sample_accepted !== want.sample_accepted)
                  report_mismatch("sample_accepted", 32'(got.sample_accepted),
                                  32'(want.sample_accepted));
               if (got.hold_left !== want.hold_left)
                  report_mismatch("hold_left", 32'(got.hold_left), 32'(want.hold_left));
               if (got.elapsed_seconds !== want.elapsed_seconds)
                  report_mismatch("elapsed_seconds", 32'(got.elapsed_seconds),
                                  32'(want.elapsed_seconds));
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               uplh_pkg::CSR_THRESHOLD:
                  presence_threshold = csr_write_data[uplh_pkg::HIST_W-1:0];
               uplh_pkg::CSR_HOLD:        hold_reload  = csr_write_data;
               uplh_pkg::CSR_GATE_ENABLE: gate_enabled = csr_write_data[0];
               uplh_pkg::CSR_GATE_LEVEL:  gate_level   = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back(predict_light(req_opcode, req_echo_count,
                                                   req_photo_level));
         end
      end
   end

   // when idling is set, hold the result side at random after each word
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (rsp_stall) begin
         if (stall_left == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left--;
         end
      end else if (rsp_valid) begin
         stall_left = idling ? $urandom_range(0, 9) : 0;
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_enable || (req_valid && !req_stall) ||
             (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

   task automatic send_word(logic [uplh_pkg::OPCODE_W-1:0] op,
                            logic [uplh_pkg::COUNT_W-1:0] count, logic photo);
      int gap;
      gap = idling ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_echo_count  <= count;
      req_photo_level <= photo;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_config(logic [uplh_pkg::HIST_W-1:0] thr,
                             logic [uplh_pkg::SECONDS_W-1:0] hold,
                             logic gate, logic level);
      csr_write_enable <= 1'b1;
      csr_index        <= uplh_pkg::CSR_THRESHOLD;
      csr_write_data   <= uplh_pkg::CSR_DATA_W'(thr);
      @(posedge clock);
      csr_index      <= uplh_pkg::CSR_HOLD;
      csr_write_data <= hold;
      @(posedge clock);
      csr_index      <= uplh_pkg::CSR_GATE_ENABLE;
      csr_write_data <= uplh_pkg::CSR_DATA_W'(gate);
      @(posedge clock);
      csr_index      <= uplh_pkg::CSR_GATE_LEVEL;
      csr_write_data <= uplh_pkg::CSR_DATA_W'(level);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_reset_values();
      send_word(uplh_pkg::OP_TICK, 16'h0000, 1'b0);
      send_word(OP_UNUSED, 16'hFFFF, 1'b1);
   endtask

   task automatic test_echo_limits();
      send_word(uplh_pkg::OP_ECHO0, 16'd0, 1'b1);
      send_word(uplh_pkg::OP_ECHO0, 16'hFFFF, 1'b0);
      send_word(uplh_pkg::OP_ECHO1, 16'd61, 1'b0);
      send_word(uplh_pkg::OP_ECHO1, 16'd62, 1'b1);
      send_word(uplh_pkg::OP_ECHO0, 16'd13235, 1'b0);
      send_word(uplh_pkg::OP_ECHO0, 16'd13236, 1'b1);
      send_word(uplh_pkg::OP_ECHO1, 16'h5555, 1'b0);
   endtask

   task automatic test_presence_hold();
      send_word(uplh_pkg::OP_TICK, 16'hAAAA, 1'b0);
      send_word(uplh_pkg::OP_TICK, 16'h5555, 1'b1);
      send_word(uplh_pkg::OP_TICK, 16'hFFFF, 1'b0);
      send_word(uplh_pkg::OP_TICK, 16'h0000, 1'b1);
   endtask

   task automatic test_photo_gate();
      drain_words();
      set_config(13'd1000, 16'd3, 1'b1, 1'b1);
      send_word(uplh_pkg::OP_ECHO0, 16'd62, 1'b0);
      send_word(uplh_pkg::OP_TICK, 16'd0, 1'b1);
      send_word(uplh_pkg::OP_TICK, 16'd0, 1'b0);
      drain_words();
      set_config(13'd1000, 16'd3, 1'b1, 1'b0);
      send_word(uplh_pkg::OP_TICK, 16'd0, 1'b0);
      send_word(uplh_pkg::OP_TICK, 16'd0, 1'b1);
   endtask

   task automatic test_threshold_zero();
      drain_words();
      set_config(13'd0, 16'd5, 1'b0, 1'b0);
      send_word(uplh_pkg::OP_ECHO1, 16'd62, 1'b0);
      send_word(uplh_pkg::OP_TICK, 16'd0, 1'b0);
   endtask

   task automatic random_word(int unsigned thr);
      int unsigned                  pick;
      int unsigned                  hi;
      logic [uplh_pkg::COUNT_W-1:0] count;
      pick  = $urandom_range(0, 99);
      count = uplh_pkg::COUNT_W'($urandom);
      hi    = thr * 3 + 100;
      if (hi > 13235) hi = 13235;
      if (pick < 40) begin
         send_word(uplh_pkg::OP_TICK, count, 1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
         send_word(pick[0] ? uplh_pkg::OP_ECHO1 : uplh_pkg::OP_ECHO0,
                   uplh_pkg::COUNT_W'($urandom_range(62, hi)),
                   1'($urandom_range(0, 1)));
      end else if (pick < 97) begin
         send_word(pick[0] ? uplh_pkg::OP_ECHO1 : uplh_pkg::OP_ECHO0, count,
                   1'($urandom_range(0, 1)));
      end else begin
         send_word(OP_UNUSED, count, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_random_traffic();
      int                             phase;
      int                             n;
      int unsigned                    thr;
      logic [uplh_pkg::SECONDS_W-1:0] hold;
      logic                           gate;
      logic                           level;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               thr = 4500; hold = 16'hFFFF; gate = 1'b0; level = 1'b0;
            end
            1: begin
               thr = 0; hold = 16'd0; gate = 1'b1; level = 1'b1;
            end
            default: begin
               thr   = $urandom_range(0, 4500);
               hold  = uplh_pkg::SECONDS_W'($urandom_range(0, 40));
               gate  = 1'($urandom_range(0, 1));
               level = 1'($urandom_range(0, 1));
            end
         endcase
         drain_words();
         idling = (phase % 3 != 2);
         set_config(uplh_pkg::HIST_W'(thr), hold, gate, level);
         for (n = 0; n < PHASE_WORDS; n++) begin
            random_word(thr);
            if (phase == 3 && n == PHASE_WORDS / 2) drain_words();
         end
      end
   endtask

   task automatic test_tick_burst();
      int n;
      drain_words();
      idling = 1'b0;
      set_config(13'd1000, 16'd8, 1'b0, 1'b0);
      for (n = 0; n < BURST_WORDS; n++) begin
         send_word(uplh_pkg::OP_TICK, uplh_pkg::COUNT_W'($urandom),
                   1'($urandom_range(0, 1)));
      end
      idling = 1'b1;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = uplh_pkg::OP_ECHO0;
      req_echo_count   = '0;
      req_photo_level  = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = uplh_pkg::CSR_THRESHOLD;
      csr_write_data   = '0;
      clear_prediction();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_echo_limits();
      test_presence_hold();
      test_photo_gate();
      test_threshold_zero();
      test_random_traffic();
      test_tick_burst();
      drain_words();
      repeat (4) @(posedge clock);
      if (expected_words.size() != 0) report_mismatch("words left over",
                                                      expected_words.size(), 32'd0);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

>>> ultrasonic_presence_light_hold_unit.f
sv/uplh_pkg.sv
sv/uplh_dist.sv
sv/ultrasonic_presence_light_hold_unit.sv
test/tb_top.sv
